>>> hdl/dct_pkg.sv
// Shared types, widths and the DCT-II basis table for the 8x8 transform.
// No dependencies.
`default_nettype none
package dct_pkg;
  localparam int N        = 8;
  localparam int IDX_W    = 3;
  localparam int ADDR_W   = 6;
  localparam int SAMPLE_W = 12;
  localparam int COEF_W   = 15;
  localparam int INTER_W  = 20;
  localparam int PROD_W   = INTER_W + COEF_W;
  localparam int ACC_W    = PROD_W + 3;
  localparam int SH1      = 10;
  localparam int SH2      = 18;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [INTER_W-1:0] inter_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_P1   = 5'b00010,
    ST_D1   = 5'b00100,
    ST_P2   = 5'b01000,
    ST_D2   = 5'b10000
  } state_t;

  // A[i][j] with 14 fraction bits, row i = frequency
  localparam coef_t BASIS [N][N] = '{
    '{15'sd5793, 15'sd5793, 15'sd5793, 15'sd5793,
      15'sd5793, 15'sd5793, 15'sd5793, 15'sd5793},
    '{15'sd8035, 15'sd6811, 15'sd4551, 15'sd1598,
      -15'sd1598, -15'sd4551, -15'sd6811, -15'sd8035},
    '{15'sd7568, 15'sd3135, -15'sd3135, -15'sd7568,
      -15'sd7568, -15'sd3135, 15'sd3135, 15'sd7568},
    '{15'sd6811, -15'sd1598, -15'sd8035, -15'sd4551,
      15'sd4551, 15'sd8035, 15'sd1598, -15'sd6811},
    '{15'sd5793, -15'sd5793, -15'sd5793, 15'sd5793,
      15'sd5793, -15'sd5793, -15'sd5793, 15'sd5793},
    '{15'sd4551, -15'sd8035, 15'sd1598, 15'sd6811,
      -15'sd6811, -15'sd1598, 15'sd8035, -15'sd4551},
    '{15'sd3135, -15'sd7568, 15'sd7568, -15'sd3135,
      -15'sd3135, 15'sd7568, -15'sd7568, 15'sd3135},
    '{15'sd1598, -15'sd4551, 15'sd6811, -15'sd8035,
      15'sd8035, -15'sd6811, 15'sd4551, -15'sd1598}
  };

  // forward uses A, inverse uses A transposed
  function automatic coef_t mat(input logic inv, input logic [IDX_W-1:0] r,
                                input logic [IDX_W-1:0] c);
    mat = inv ? BASIS[c][r] : BASIS[r][c];
  endfunction
endpackage
`default_nettype wire

>>> hdl/dct_8x8_forward_inverse_top.sv
// 8x8 forward/inverse 2-D DCT, two passes through one shared MAC.
// Depends on dct_pkg.
`default_nettype none
// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+------------------
// input     | in_sample                                     | start & !busy
// result    | out_coefficient, out_last_of_block            | out_strobe
// config    | cfg_direction                                 | cfg_valid&cfg_ready
//
// Cycles: one word per cycle while loading and start is high. After the 64th
// sample the block is busy for both passes, each a MAC phase plus a drain; the
// single multiply-accumulate unit performs both. Results stream out during pass
// two and its drain. Reset clears control only; stores need no clearing.
// The receiver cannot stall: each result is valid for exactly one cycle.
module dct_8x8_forward_inverse_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [dct_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                out_strobe,
  output logic [dct_pkg::SAMPLE_W-1:0]        out_coefficient,
  output logic                                out_last_of_block,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_direction
);
  import dct_pkg::*;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0]  load_cnt_r;
  logic [3*IDX_W-1:0] cnt_r;      // {i, j, k}
  logic [1:0]         drain_r;
  logic               dir_r;

  logic signed [SAMPLE_W-1:0] blk_mem [64];
  inter_t                     int_mem [64];
  logic signed [SAMPLE_W-1:0] blk_rd_r;
  inter_t                     int_rd_r;

  // pipeline tags
  logic v1_r, f1_r, l1_r, p2_1_r;
  logic v2_r, f2_r, l2_r, p2_2_r;
  logic v3_r, p2_3_r;
  logic [ADDR_W-1:0] idx1_r, idx2_r, idx3_r;
  coef_t coef_r;
  prod_t prod_r;
  acc_t  acc_r;

  logic [IDX_W-1:0] ci, cj, ck;
  logic issue, accept;
  assign {ci, cj, ck} = cnt_r;
  assign issue  = (state_r == ST_P1) || (state_r == ST_P2);
  assign accept = start && !busy;
  assign busy      = (state_r != ST_LOAD);
  assign cfg_ready = !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (accept && load_cnt_r == ADDR_W'(63)) state_nxt = ST_P1;
      ST_P1:   if (cnt_r == '1) state_nxt = ST_D1;
      ST_D1:   if (drain_r == '1) state_nxt = ST_P2;
      ST_P2:   if (cnt_r == '1) state_nxt = ST_D2;
      ST_D2:   if (drain_r == '1) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      cnt_r      <= '0;
      drain_r    <= '0;
      dir_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) dir_r <= cfg_direction;
      if (accept) load_cnt_r <= load_cnt_r + ADDR_W'(1);
      if (issue) cnt_r <= cnt_r + 9'd1;
      if (state_r == ST_D1 || state_r == ST_D2) drain_r <= drain_r + 2'd1;
      else drain_r <= '0;
    end
  end

  // memories: synchronous read, one write port each
  always_ff @(posedge clk) begin
    if (accept) blk_mem[load_cnt_r] <= $signed(in_sample);
    blk_rd_r <= blk_mem[{ck, cj}];
    int_rd_r <= int_mem[{ci, ck}];
  end

  // stage 1: address issued, coefficient picked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r && l2_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_r   <= (ck == '0);
    l1_r   <= (ck == '1);
    p2_1_r <= (state_r == ST_P2);
    idx1_r <= {ci, cj};
    coef_r <= (state_r == ST_P2) ? mat(dir_r, cj, ck) : mat(dir_r, ci, ck);
    // stage 2: multiply
    prod_r <= (p2_1_r ? int_rd_r : INTER_W'(blk_rd_r)) * coef_r;
    f2_r   <= f1_r; l2_r <= l1_r; p2_2_r <= p2_1_r; idx2_r <= idx1_r;
    // stage 3: accumulate
    if (v2_r) acc_r <= (f2_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
    p2_3_r <= p2_2_r; idx3_r <= idx2_r;
  end

  // round half up, shift, saturate
  acc_t r1, r2;
  inter_t sat1;
  logic signed [SAMPLE_W-1:0] sat2;
  always_comb begin
    r1 = (acc_r + (ACC_W'(1) <<< (SH1 - 1))) >>> SH1;
    r2 = (acc_r + (ACC_W'(1) <<< (SH2 - 1))) >>> SH2;
    if (r1 > ACC_W'(2**(INTER_W-1) - 1))       sat1 = {1'b0, {(INTER_W-1){1'b1}}};
    else if (r1 < -ACC_W'(2**(INTER_W-1)))     sat1 = {1'b1, {(INTER_W-1){1'b0}}};
    else                                       sat1 = r1[INTER_W-1:0];
    if (r2 > ACC_W'(2**(SAMPLE_W-1) - 1))      sat2 = {1'b0, {(SAMPLE_W-1){1'b1}}};
    else if (r2 < -ACC_W'(2**(SAMPLE_W-1)))    sat2 = {1'b1, {(SAMPLE_W-1){1'b0}}};
    else                                       sat2 = r2[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (v3_r && !p2_3_r) int_mem[idx3_r] <= sat1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= v3_r && p2_3_r;
    out_coefficient   <= sat2;
    out_last_of_block <= (idx3_r == '1);
  end

  ap_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result outside transform");
  ap_go: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && state_nxt == ST_P1) |-> load_cnt_r == ADDR_W'(63))
    else $error("transform started on partial block");
  ap_wb_p1: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !p2_3_r) |-> (state_r == ST_P1 || state_r == ST_D1))
    else $error("pass one writeback out of phase");
endmodule
`default_nettype wire
